// ----- design/tlbw_pkg.sv -----
// Package for the TLB with two-level page walk.
// Holds the payload structs, command and result codes, and the controller/datapath buses.
// No dependencies.
package tlbw_pkg;

	// Default number of TLB slots
	localparam int TLBW_ENTRIES = 64;

	// Field widths
	localparam int ADDR_W = 32;
	localparam int TAG_W  = 20;
	localparam int PDB_W  = 20;

	// Input command codes
	localparam logic [1:0] CMD_TRANSLATE = 2'd0;
	localparam logic [1:0] CMD_MEM_DATA  = 2'd1;
	localparam logic [1:0] CMD_FLUSH     = 2'd2;

	// Result kind codes
	localparam logic [2:0] KIND_DONE      = 3'd0;
	localparam logic [2:0] KIND_READ      = 3'd1;
	localparam logic [2:0] KIND_DIR_FAULT = 3'd2;
	localparam logic [2:0] KIND_TBL_FAULT = 3'd3;
	localparam logic [2:0] KIND_FLUSHED   = 3'd4;

	// Result address select
	localparam logic [1:0] ASEL_ZERO = 2'd0;
	localparam logic [1:0] ASEL_DIR  = 2'd1;
	localparam logic [1:0] ASEL_TBL  = 2'd2;

	typedef struct packed {
		logic [1:0]        command;
		logic [ADDR_W-1:0] lin_addr;
		logic [ADDR_W-1:0] mem_data;
	} tlbw_req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ADDR_W-1:0] entry_word;
		logic [ADDR_W-1:0] mem_addr;
	} tlbw_rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture_pending;
		logic       flush;
		logic       stage;
		logic [2:0] stage_kind;
		logic [1:0] stage_asel;
		logic       stage_word;
		logic       ram_read;
		logic       fill_free;
		logic       victim_start;
		logic       fill_victim;
		logic       load_out;
		logic       out_from_ram;
	} tlbw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] req_cmd;
		logic       present;
		logic       hit;
		logic       any_free;
		logic       victim_done;
		logic       out_free;
	} tlbw_sts_t;

endpackage

// ----- design/tlb_with_two_level_page_walk_unit.sv -----
// Top level of the fully associative TLB with x86 two-level page walk.
// Depends on tlbw_pkg, tlbw_ctrl and tlbw_dp.
//
// One item is handled at a time. A flush, a fault, a read request or a hit passes through
// one sequencer state (response or hit) before the next transfer is accepted; the hit path
// does the parallel tag compare and then the registered PTE RAM read. The final walk step
// that fills a free slot passes through the fill and response states. When every slot is
// valid, the victim slot comes from a four-stage remainder pipeline in the victim state. A
// finished result waits in an output register; the next transfer is taken while it waits.
// Accessed and dirty bits are never written back.
module tlb_with_two_level_page_walk_unit import tlbw_pkg::*; #(
	parameter int ENTRIES = TLBW_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  tlbw_req_t        req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output tlbw_rsp_t        rsp,
	input  logic             cfg_wr_en,
	input  logic [PDB_W-1:0] cfg_wr_data
);

	tlbw_cmd_t cmd;
	tlbw_sts_t sts;

	tlbw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlbw_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rsp_stall   (rsp_stall),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

// ----- design/tlbw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Uses no package.
module tlbw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tlbw_victim_mod.sv -----
// Victim slot unit: (tag * seed + 31) mod ENTRIES through a four-stage pipeline,
// using a reciprocal multiply and one correcting subtract.
// Depends on tlbw_pkg for the tag width.
module tlbw_victim_mod import tlbw_pkg::*; #(
	parameter int ENTRIES = TLBW_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [TAG_W-1:0]           tag,
	input  logic [$clog2(ENTRIES)-1:0] seed,
	output logic                       done,
	output logic [$clog2(ENTRIES)-1:0] result
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int YW    = TAG_W + IDX_W;
	localparam logic [YW-1:0]  OFFSET = YW'(31);
	localparam logic [YW-1:0]  MODC_Y = YW'(ENTRIES);
	localparam logic [IDX_W:0] MODC   = (IDX_W+1)'(ENTRIES);
	// floor(2^YW / ENTRIES); the quotient estimate is never high and at most one low
	localparam logic [YW-1:0]  RECIP  = YW'((64'd1 << YW) / ENTRIES);

	logic             v_s1;
	logic             v_s2;
	logic             v_s3;
	logic             done_q;
	logic [YW-1:0]    y_s1;
	logic [YW-1:0]    y_s2;
	logic [YW-1:0]    quot_s2;
	logic [IDX_W:0]   rem_d;
	logic [IDX_W:0]   rem_s3;
	logic [IDX_W-1:0] result_q;

	// Remainder before the final correction, below 2 * ENTRIES
	assign rem_d = (IDX_W+1)'(y_s2 - quot_s2 * MODC_Y);

	// Stage valids and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	// Product, quotient estimate, remainder, correction
	always_ff @(posedge clk) begin
		if (start) begin
			y_s1 <= YW'(tag) * YW'(seed) + OFFSET;
		end
		if (v_s1) begin
			y_s2    <= y_s1;
			quot_s2 <= YW'(((2*YW)'(y_s1) * (2*YW)'(RECIP)) >> YW);
		end
		if (v_s2) begin
			rem_s3 <= rem_d;
		end
		if (v_s3) begin
			result_q <= (rem_s3 >= MODC) ? IDX_W'(rem_s3 - MODC) : rem_s3[IDX_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- design/tlbw_dp.sv -----
// Datapath: tag CAM, valid bits, PTE RAM, free-slot tree, victim unit and result registers.
// Depends on tlbw_pkg, tlbw_ram and tlbw_victim_mod.
module tlbw_dp import tlbw_pkg::*; #(
	parameter int ENTRIES = TLBW_ENTRIES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tlbw_req_t        req,
	input  logic             cfg_wr_en,
	input  logic [PDB_W-1:0] cfg_wr_data,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output tlbw_rsp_t        rsp,
	input  tlbw_cmd_t        cmd,
	output tlbw_sts_t        sts
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int GRP   = 8;
	localparam int NG    = (ENTRIES + GRP - 1) / GRP;

	// Architectural state
	logic [ENTRIES-1:0] valid_q;
	logic [TAG_W-1:0]   tag_q [ENTRIES];
	logic [IDX_W-1:0]   seed_q;
	logic [PDB_W-1:0]   pdb_q;
	logic [ADDR_W-1:0]  pending_q;

	// Staged result and output register
	logic [2:0]        kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] word_q;
	tlbw_rsp_t         out_q;
	logic              out_valid_q;

	// Free-slot tree, first level registered
	logic [NG*GRP-1:0] vld_pad;
	logic [NG-1:0]     grp_free_d;
	logic [NG-1:0]     grp_free_q;
	logic [IDX_W-1:0]  grp_idx_d [NG];
	logic [IDX_W-1:0]  grp_idx_q [NG];
	logic [IDX_W-1:0]  free_idx;

	logic [ENTRIES-1:0] match;
	logic [IDX_W-1:0]   hit_idx;
	logic [TAG_W-1:0]   req_tag;
	logic [ADDR_W-1:0]  stage_addr;
	logic [ADDR_W-1:0]  ram_rdata;
	logic               fill;
	logic [IDX_W-1:0]   fill_slot;
	logic               vict_done;
	logic [IDX_W-1:0]   vict_slot;

	assign req_tag = req.lin_addr[ADDR_W-1:ADDR_W-TAG_W];

	// Parallel tag compare and binary encode of the one-hot match into the hit slot
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == req_tag);
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	// Lowest invalid slot in each group of eight
	always_comb begin
		vld_pad = '1;
		for (int i = 0; i < ENTRIES; i++) begin
			vld_pad[i] = valid_q[i];
		end
		for (int g = 0; g < NG; g++) begin
			grp_free_d[g] = 1'b0;
			grp_idx_d[g]  = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (!vld_pad[g*GRP + j]) begin
					grp_free_d[g] = 1'b1;
					grp_idx_d[g]  = IDX_W'(g*GRP + j);
				end
			end
		end
	end

	// Second level: lowest group with a free slot
	always_comb begin
		free_idx = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_free_q[g]) begin
				free_idx = grp_idx_q[g];
			end
		end
	end

	// Result address for read requests
	always_comb begin
		case (cmd.stage_asel)
			ASEL_DIR: stage_addr = {pdb_q, req.lin_addr[31:22], 2'b00};
			ASEL_TBL: stage_addr = {req.mem_data[31:12], pending_q[21:12], 2'b00};
			default:  stage_addr = '0;
		endcase
	end

	assign fill      = cmd.fill_free || cmd.fill_victim;
	assign fill_slot = cmd.fill_free ? free_idx : vict_slot;

	// Control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			seed_q      <= '0;
			pdb_q       <= '0;
			pending_q   <= '0;
			out_valid_q <= 1'b0;
			grp_free_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				pdb_q <= cfg_wr_data;
			end
			if (cmd.capture_pending) begin
				pending_q <= req.lin_addr;
			end
			if (cmd.flush) begin
				valid_q <= '0;
			end else if (fill) begin
				valid_q[fill_slot] <= 1'b1;
			end
			if (cmd.fill_victim) begin
				seed_q <= vict_slot;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			grp_free_q <= grp_free_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		grp_idx_q <= grp_idx_d;
		if (fill) begin
			tag_q[fill_slot] <= pending_q[ADDR_W-1:ADDR_W-TAG_W];
		end
		if (cmd.stage) begin
			kind_q <= cmd.stage_kind;
			addr_q <= stage_addr;
			word_q <= cmd.stage_word ? req.mem_data : '0;
		end
		if (cmd.load_out) begin
			out_q.kind       <= kind_q;
			out_q.entry_word <= cmd.out_from_ram ? ram_rdata : word_q;
			out_q.mem_addr   <= addr_q;
		end
	end

	// Cached PTE words
	tlbw_ram #(
		.WIDTH (ADDR_W),
		.DEPTH (ENTRIES)
	) u_pte_ram (
		.clk   (clk),
		.we    (fill),
		.waddr (fill_slot),
		.wdata (word_q),
		.re    (cmd.ram_read),
		.raddr (hit_idx),
		.rdata (ram_rdata)
	);

	// Replacement slot when every entry is valid
	tlbw_victim_mod #(
		.ENTRIES (ENTRIES)
	) u_victim (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.victim_start),
		.tag    (pending_q[ADDR_W-1:ADDR_W-TAG_W]),
		.seed   (seed_q),
		.done   (vict_done),
		.result (vict_slot)
	);

	// Status to the controller
	always_comb begin
		sts.req_cmd     = req.command;
		sts.present     = req.mem_data[0];
		sts.hit         = |match;
		sts.any_free    = |grp_free_q;
		sts.victim_done = vict_done;
		sts.out_free    = !out_valid_q || !rsp_stall;
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A hit read must come from exactly one matching slot
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ram_read |-> $onehot(match))
		else $error("RAM read without a unique tag match");

	// Flush leaves no valid entry
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (valid_q == '0))
		else $error("valid bits remain after flush");

	// A filled slot becomes valid
	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		fill |=> valid_q[$past(fill_slot)])
		else $error("filled slot not marked valid");

endmodule

// ----- design/tlbw_ctrl.sv -----
// Controller: sequencer state, page walk phase and input handshake.
// Depends on tlbw_pkg for command/status buses and codes.
module tlbw_ctrl import tlbw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  tlbw_sts_t sts,
	output tlbw_cmd_t cmd
);

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HIT  = 3'd1;
	localparam logic [2:0] S_FILL = 3'd2;
	localparam logic [2:0] S_VICT = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	// Walk phases
	localparam logic [1:0] WALK_IDLE = 2'd0;
	localparam logic [1:0] WALK_DIR  = 2'd1;
	localparam logic [1:0] WALK_TBL  = 2'd2;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] walk_q;
	logic [1:0] walk_d;

	assign req_stall = (state_q != S_IDLE);

	// Next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		walk_d  = walk_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (sts.req_cmd)
						CMD_FLUSH: begin
							cmd.flush      = 1'b1;
							cmd.stage      = 1'b1;
							cmd.stage_kind = KIND_FLUSHED;
							walk_d         = WALK_IDLE;
							state_d        = S_RESP;
						end
						CMD_TRANSLATE: begin
							if (walk_q == WALK_IDLE) begin
								cmd.stage = 1'b1;
								if (sts.hit) begin
									cmd.stage_kind = KIND_DONE;
									cmd.ram_read   = 1'b1;
									state_d        = S_HIT;
								end else begin
									cmd.capture_pending = 1'b1;
									cmd.stage_kind      = KIND_READ;
									cmd.stage_asel      = ASEL_DIR;
									walk_d              = WALK_DIR;
									state_d             = S_RESP;
								end
							end
						end
						CMD_MEM_DATA: begin
							case (walk_q)
								WALK_DIR: begin
									cmd.stage = 1'b1;
									state_d   = S_RESP;
									if (sts.present) begin
										cmd.stage_kind = KIND_READ;
										cmd.stage_asel = ASEL_TBL;
										walk_d         = WALK_TBL;
									end else begin
										cmd.stage_kind = KIND_DIR_FAULT;
										walk_d         = WALK_IDLE;
									end
								end
								WALK_TBL: begin
									cmd.stage = 1'b1;
									walk_d    = WALK_IDLE;
									if (sts.present) begin
										cmd.stage_kind = KIND_DONE;
										cmd.stage_word = 1'b1;
										state_d        = S_FILL;
									end else begin
										cmd.stage_kind = KIND_TBL_FAULT;
										state_d        = S_RESP;
									end
								end
								default: begin
								end
							endcase
						end
						default: begin
						end
					endcase
				end
			end
			S_HIT: begin
				if (sts.out_free) begin
					cmd.load_out     = 1'b1;
					cmd.out_from_ram = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_FILL: begin
				if (sts.any_free) begin
					cmd.fill_free = 1'b1;
					state_d       = S_RESP;
				end else begin
					cmd.victim_start = 1'b1;
					state_d          = S_VICT;
				end
			end
			S_VICT: begin
				if (sts.victim_done) begin
					cmd.fill_victim = 1'b1;
					state_d         = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			walk_q  <= WALK_IDLE;
		end else begin
			state_q <= state_d;
			walk_q  <= walk_d;
		end
	end

	// Output register is only loaded when it is free or draining
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> sts.out_free)
		else $error("result loaded over an untaken transfer");

	// Direct fill only when the free-slot tree reports a slot
	a_fill_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_free |-> sts.any_free)
		else $error("fill into a full TLB without a victim");

	// Translate during a walk produces nothing and leaves the walk going
	a_walk_ignores: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req_valid && sts.req_cmd == CMD_TRANSLATE
			&& walk_q != WALK_IDLE) |=> (state_q == S_IDLE && walk_q == $past(walk_q)))
		else $error("translate during walk was not ignored");

endmodule
